// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the cosine similarity checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cse_checker: property violated");

// Check a property on every clock edge, reset cycles included.
`define CSE_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cse_checker: reset property violated");

`endif

// ----- rtl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants, item type and IEEE single arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W  = 3;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // Accumulator set selector
  typedef enum logic [1:0] {
    OP_DOT = 2'd0,
    OP_NA  = 2'd1,
    OP_NB  = 2'd2
  } cse_op_t;

  // One classified item as it crosses the queue
  typedef struct packed {
    logic [LANES-1:0][31:0] a;
    logic [LANES-1:0][31:0] b;
    logic [LANES-1:0]       mask;
    logic                   last;
  } cse_item_t;

  // Index of the highest set bit
  function automatic logic [5:0] msb48(logic [47:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Right shift that folds lost bits into bit 0
  function automatic logic [26:0] shr_sticky(logic [26:0] v, logic [11:0] sh);
    logic [5:0]  s;
    logic [53:0] w;
    s = (sh > 12'd27) ? 6'd28 : sh[5:0];
    w = {v, 27'd0} >> s;
    return w[53:27] | {26'd0, |w[26:0]};
  endfunction

  // Round to nearest even and pack; sig has its leading one at bit 26
  function automatic logic [31:0] fp_pack(logic s, logic signed [11:0] e, logic [26:0] sig);
    logic [26:0] sv;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] w;
    if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
    if (e <= 12'sd0) begin
      sv = shr_sticky(sig, 12'd1 - 12'(e));
      ef = 8'd0;
    end else begin
      sv = sig;
      ef = e[7:0];
    end
    inc = sv[2] & ((|sv[1:0]) | sv[3]);
    w   = {ef, sv[25:3]} + 31'(inc);
    return {s, w};
  endfunction

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic signed [11:0] eff_exp(logic [31:0] x);
    return (x[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, x[30:23]});
  endfunction

  // IEEE single multiply
  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic                s;
    logic [23:0]         ma, mb;
    logic [47:0]         p, pn;
    logic [5:0]          l;
    logic signed [11:0]  e;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
      return CANON_NAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    l  = msb48(p);
    pn = p << (6'd47 - l);
    e  = $signed({6'd0, l}) + eff_exp(a) + eff_exp(b) - 12'sd173;
    return fp_pack(s, e, {pn[47:22], |pn[21:0]});
  endfunction

  // IEEE single add
  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]        big, sml;
    logic signed [11:0] eb, es, e;
    logic [26:0]        x, y;
    logic [27:0]        sum, sn;
    logic [5:0]         l;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return CANON_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = eff_exp(big);
    es = eff_exp(sml);
    x  = {big[30:23] != 8'd0, big[22:0], 3'd0};
    y  = shr_sticky({sml[30:23] != 8'd0, sml[22:0], 3'd0}, 12'(eb - es));
    if (big[31] == sml[31]) sum = {1'b0, x} + {1'b0, y};
    else                    sum = {1'b0, x} - {1'b0, y};
    if (sum == 28'd0) return 32'd0;
    l  = msb48({20'd0, sum});
    sn = sum << (6'd27 - l);
    e  = $signed({6'd0, l}) + eb - 12'sd26;
    return fp_pack(big[31], e, sn[27:1] | {26'd0, sn[0]});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cse_ifs.sv -----
// ----------------------------------------------------------------------------
// cse_ifs
// Valid/ready channels for input items and similarity results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cse_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [cse_pkg::LANES-1:0][31:0]        a_lane;
  logic [cse_pkg::LANES-1:0][31:0]        b_lane;
  logic [cse_pkg::CNT_W-1:0]              valid_lanes;
  logic                                   last;

  modport source (output valid, a_lane, b_lane, valid_lanes, last, input ready);
  modport sink   (input valid, a_lane, b_lane, valid_lanes, last, output ready);
endinterface

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] similarity;

  modport source (output valid, similarity, input ready);
  modport sink   (input valid, similarity, output ready);
endinterface

`default_nettype wire

// ----- rtl/cse_front.sv -----
// ----------------------------------------------------------------------------
// cse_front
// Accepts input items, builds the lane mask and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  cse_in_if.sink                  in_ch,
  output cse_pkg::cse_item_t      item_data,
  output logic                    item_valid,
  input  wire logic               item_pop
);

  cse_pkg::cse_item_t             fifo_r [cse_pkg::QDEPTH];
  logic [cse_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cse_pkg::QPTR_W:0]       count_r;
  cse_pkg::cse_item_t             cls;
  logic                           push, pop;

  // Classify: lanes past the count on a last item contribute nothing
  always_comb begin
    cls.a    = in_ch.a_lane;
    cls.b    = in_ch.b_lane;
    cls.last = in_ch.last;
    for (int i = 0; i < cse_pkg::LANES; i++) begin
      cls.mask[i] = !in_ch.last || (32'(in_ch.valid_lanes) > i);
    end
  end

  assign in_ch.ready = (count_r != (cse_pkg::QPTR_W+1)'(cse_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (count_r != '0);
  assign pop         = item_pop && item_valid;
  assign item_data   = fifo_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= cls;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cse_sqrt.sv -----
// ----------------------------------------------------------------------------
// cse_sqrt
// Iterative IEEE single square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output logic             done,
  output logic [31:0]      result
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_RND, S_DONE} sq_state_t;

  sq_state_t            state_r;
  logic [51:0]          n_r, res_r, bit_r;
  logic signed [11:0]   e_r;
  logic [31:0]          result_r;

  logic [23:0]          m24;
  logic [24:0]          m25;
  logic [5:0]           lpos;
  logic [4:0]           shn;
  logic signed [11:0]   e0;
  logic [51:0]          t;
  logic                 two, rbit, st;
  logic [23:0]          q24;
  logic [24:0]          qr;
  logic [1:0]           dd;
  logic signed [11:0]   bexp;

  assign done   = (state_r == S_DONE);
  assign result = result_r;

  // Operand set-up and rounding
  always_comb begin
    lpos = cse_pkg::msb48({25'd0, x[22:0]});
    shn  = 5'(6'd23 - lpos);
    if (x[30:23] == 8'd0) begin
      m24 = {1'b0, x[22:0]} << shn;
      e0  = -12'sd149 - $signed({7'd0, shn});
    end else begin
      m24 = {1'b1, x[22:0]};
      e0  = $signed({4'd0, x[30:23]}) - 12'sd150;
    end
    m25 = e0[0] ? {m24, 1'b0} : {1'b0, m24};
    t   = res_r + bit_r;
    two  = res_r[25];
    q24  = two ? res_r[25:2] : res_r[24:1];
    rbit = two ? res_r[1] : res_r[0];
    st   = (two & res_r[0]) | (n_r != 52'd0);
    qr   = {1'b0, q24} + 25'(rbit & (st | q24[0]));
    dd   = two ? 2'd2 : 2'd1;
    if (qr[24]) dd = dd + 2'd1;
    bexp = $signed({10'd0, dd}) + (e_r >>> 1) - 12'sd13 + 12'sd150;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (cse_pkg::is_nan(x)) begin
              result_r <= cse_pkg::CANON_NAN;
              state_r  <= S_DONE;
            end else if (cse_pkg::is_zero(x)) begin
              result_r <= x;
              state_r  <= S_DONE;
            end else if (x[31]) begin
              result_r <= cse_pkg::CANON_NAN;
              state_r  <= S_DONE;
            end else if (cse_pkg::is_inf(x)) begin
              result_r <= x;
              state_r  <= S_DONE;
            end else begin
              n_r     <= {1'b0, m25, 26'd0};
              res_r   <= '0;
              bit_r   <= 52'd1 << 50;
              e_r     <= e0[0] ? e0 - 12'sd1 : e0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (n_r >= t) begin
            n_r   <= n_r - t;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= S_RND;
        end
        S_RND: begin
          result_r <= {1'b0, bexp[7:0], qr[24] ? qr[23:1] : qr[22:0]};
          state_r  <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cse_div.sv -----
// ----------------------------------------------------------------------------
// cse_div
// Iterative IEEE single divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      result
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_RND, S_DONE} dv_state_t;

  dv_state_t            state_r;
  logic [25:0]          rem_r;
  logic [23:0]          mb_r;
  logic [27:0]          q_r;
  logic [4:0]           cnt_r;
  logic signed [11:0]   e_r;
  logic                 s_r;
  logic [31:0]          result_r;

  logic [5:0]           la, lb;
  logic [23:0]          ma, mb;
  logic signed [11:0]   ea, eb;
  logic                 s, qbit;
  logic [25:0]          rdiff;
  logic [26:0]          sig;
  logic signed [11:0]   ef;

  assign done   = (state_r == S_DONE);
  assign result = result_r;

  // Normalize operands, one division step, final packing
  always_comb begin
    s  = num[31] ^ den[31];
    la = cse_pkg::msb48({24'd0, num[30:23] != 8'd0, num[22:0]});
    lb = cse_pkg::msb48({24'd0, den[30:23] != 8'd0, den[22:0]});
    ma = {num[30:23] != 8'd0, num[22:0]} << (6'd23 - la);
    mb = {den[30:23] != 8'd0, den[22:0]} << (6'd23 - lb);
    ea = cse_pkg::eff_exp(num) - $signed({6'd0, 6'd23 - la});
    eb = cse_pkg::eff_exp(den) - $signed({6'd0, 6'd23 - lb});
    qbit  = (rem_r >= {2'd0, mb_r});
    rdiff = qbit ? rem_r - {2'd0, mb_r} : rem_r;
    if (q_r[27]) begin
      sig = q_r[27:1] | {26'd0, (q_r[0] | (rem_r != 26'd0))};
      ef  = e_r;
    end else begin
      sig = q_r[26:0] | {26'd0, (rem_r != 26'd0)};
      ef  = e_r - 12'sd1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (cse_pkg::is_nan(num) || cse_pkg::is_nan(den) ||
                (cse_pkg::is_inf(num) && cse_pkg::is_inf(den)) ||
                (cse_pkg::is_zero(num) && cse_pkg::is_zero(den))) begin
              result_r <= cse_pkg::CANON_NAN;
              state_r  <= S_DONE;
            end else if (cse_pkg::is_inf(num) || cse_pkg::is_zero(den)) begin
              result_r <= {s, 8'hFF, 23'd0};
              state_r  <= S_DONE;
            end else if (cse_pkg::is_inf(den) || cse_pkg::is_zero(num)) begin
              result_r <= {s, 31'd0};
              state_r  <= S_DONE;
            end else begin
              rem_r   <= {2'd0, ma};
              mb_r    <= mb;
              q_r     <= '0;
              cnt_r   <= '0;
              e_r     <= ea - eb + 12'sd127;
              s_r     <= s;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          q_r   <= {q_r[26:0], qbit};
          rem_r <= {rdiff[24:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd27) state_r <= S_RND;
        end
        S_RND: begin
          // Remainder was doubled after the last step; zero test still holds
          result_r <= cse_pkg::fp_pack(s_r, ef, sig);
          state_r  <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cse_back.sv -----
// ----------------------------------------------------------------------------
// cse_back
// Executes queued items: lane accumulation, lane reduction, norms and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cse_pkg::cse_item_t      item_data,
  input  wire logic               item_valid,
  output logic                    item_pop,
  cse_out_if.source               out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_RLOAD, S_RED, S_SQA_GO, S_SQA_W,
    S_SQB_GO, S_SQB_W, S_DEN, S_DIV_GO, S_DIV_W, S_OUT
  } bk_state_t;

  bk_state_t                  state_r;
  cse_pkg::cse_item_t         item_r;
  logic [cse_pkg::LANE_W-1:0] lane_r, rl_r;
  cse_pkg::cse_op_t           op_r, k_r;
  logic [31:0]                acc_r [3][cse_pkg::LANES];
  logic [31:0]                red_r [3];
  logic [31:0]                prod_r, sum_r, sa_r, sb_r, den_r, sim_r;
  logic                       out_valid_r;
  logic [31:0]                out_sim_r;

  logic [31:0]                mx, my, radd, sq_res, dv_res;
  logic                       sq_done, dv_done, sq_start, dv_start;
  logic                       lane_end, rl_end;
  cse_pkg::cse_op_t           op_next, k_next;

  assign item_pop          = (state_r == S_IDLE) && item_valid;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.similarity = out_sim_r;
  assign sq_start          = (state_r == S_SQA_GO) || (state_r == S_SQB_GO);
  assign dv_start          = (state_r == S_DIV_GO);
  assign lane_end          = (lane_r == cse_pkg::LANE_W'(cse_pkg::LANES - 1));
  assign rl_end            = (rl_r == cse_pkg::LANE_W'(cse_pkg::LANES - 1));
  assign radd              = cse_pkg::fp_add(sum_r, acc_r[k_r][rl_r]);

  // Operand selection for the lane multiplier
  always_comb begin
    case (op_r)
      cse_pkg::OP_DOT: begin
        mx = item_r.a[lane_r];
        my = item_r.b[lane_r];
      end
      cse_pkg::OP_NA: begin
        mx = item_r.a[lane_r];
        my = item_r.a[lane_r];
      end
      default: begin
        mx = item_r.b[lane_r];
        my = item_r.b[lane_r];
      end
    endcase
    case (op_r)
      cse_pkg::OP_DOT: op_next = cse_pkg::OP_NA;
      cse_pkg::OP_NA:  op_next = cse_pkg::OP_NB;
      default:         op_next = cse_pkg::OP_DOT;
    endcase
    case (k_r)
      cse_pkg::OP_DOT: k_next = cse_pkg::OP_NA;
      cse_pkg::OP_NA:  k_next = cse_pkg::OP_NB;
      default:         k_next = cse_pkg::OP_DOT;
    endcase
  end

  cse_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .x      ((state_r == S_SQA_GO) ? red_r[cse_pkg::OP_NA] : red_r[cse_pkg::OP_NB]),
    .done   (sq_done),
    .result (sq_res)
  );

  cse_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dv_start),
    .num    (red_r[cse_pkg::OP_DOT]),
    .den    (den_r),
    .done   (dv_done),
    .result (dv_res)
  );

  // Sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < cse_pkg::LANES; l++) acc_r[k][l] <= 32'd0;
      end
    end else begin
      // Drop out valid after the transfer unless a new result loads now
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            item_r  <= item_data;
            lane_r  <= '0;
            op_r    <= cse_pkg::OP_DOT;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (item_r.mask[lane_r]) begin
            prod_r  <= cse_pkg::fp_mul(mx, my);
            state_r <= S_ADD;
          end else if (lane_end) begin
            k_r     <= cse_pkg::OP_DOT;
            state_r <= item_r.last ? S_RLOAD : S_IDLE;
          end else begin
            lane_r <= lane_r + 1'b1;
          end
        end
        S_ADD: begin
          acc_r[op_r][lane_r] <= cse_pkg::fp_add(acc_r[op_r][lane_r], prod_r);
          op_r <= op_next;
          if (op_r != cse_pkg::OP_NB) begin
            state_r <= S_MUL;
          end else if (lane_end) begin
            k_r     <= cse_pkg::OP_DOT;
            state_r <= item_r.last ? S_RLOAD : S_IDLE;
          end else begin
            lane_r  <= lane_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        // Sum lanes left to right, one set at a time
        S_RLOAD: begin
          if (cse_pkg::LANES == 1) begin
            red_r[k_r] <= acc_r[k_r][0];
            k_r        <= k_next;
            if (k_r == cse_pkg::OP_NB) state_r <= S_SQA_GO;
          end else begin
            sum_r   <= acc_r[k_r][0];
            rl_r    <= cse_pkg::LANE_W'(1);
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (rl_end) begin
            red_r[k_r] <= radd;
            k_r        <= k_next;
            state_r    <= (k_r == cse_pkg::OP_NB) ? S_SQA_GO : S_RLOAD;
          end else begin
            sum_r <= radd;
            rl_r  <= rl_r + 1'b1;
          end
        end
        S_SQA_GO: begin
          // Sums are captured; clear for the next vector pair
          for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < cse_pkg::LANES; l++) acc_r[k][l] <= 32'd0;
          end
          state_r <= S_SQA_W;
        end
        S_SQA_W: begin
          if (sq_done) begin
            sa_r    <= sq_res;
            state_r <= S_SQB_GO;
          end
        end
        S_SQB_GO: state_r <= S_SQB_W;
        S_SQB_W: begin
          if (sq_done) begin
            sb_r    <= sq_res;
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den_r   <= cse_pkg::fp_mul(sa_r, sb_r);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_W;
        S_DIV_W: begin
          if (dv_done) begin
            sim_r   <= cse_pkg::is_nan(dv_res) ? cse_pkg::CANON_NAN : dv_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_sim_r   <= sim_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cosine_similarity_engine.sv -----
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two IEEE single vectors, four lanes per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries four A/B element pairs, a lane count and a last flag; a
//   transfer happens when valid and ready are both high. The lane count only
//   matters on the last item. out_ch carries one similarity word per vector
//   pair, after the item marked last.
//   Items enter a two-entry queue; the back end works one item at a time,
//   one multiply and one add at a time: for each active lane it multiplies
//   and accumulates the dot product, the A norm and the B norm in turn, and
//   it skips idle lanes. A last item adds the lane reduction, two square
//   roots (one bit pair per cycle), one multiply and a 28-step divide
//   before the result shows on out_ch.
//   Reset (rst_n low at a clock edge) empties the queue, clears all
//   accumulators to +0 and drops out valid.
//   When the receiver stalls the result stays in the output register; the
//   back end keeps working and holds only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_engine (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cse_in_if.sink      in_ch,
  cse_out_if.source   out_ch
);

  cse_pkg::cse_item_t item_data;
  logic               item_valid;
  logic               item_pop;

  cse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_data  (item_data),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  cse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_data  (item_data),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/cse_checker.sv -----
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks on the cosine similarity engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_similarity
);

  logic res_nan;

  // Flag a NaN pattern on the result bus
  assign res_nan = (out_similarity[30:23] == 8'hFF) && (out_similarity[22:0] != 23'd0);

  // Reset leaves the queue empty and no result pending
  `CSE_ASSERT_NR(a_reset_state, !rst_n |=> (in_ready && !out_valid))

  // NaN results always come out as the canonical quiet NaN
  `CSE_ASSERT(a_canon_nan, out_valid && res_nan |-> (out_similarity == cse_pkg::CANON_NAN))

  // A stalled result stays offered and unchanged
  `CSE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `CSE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_similarity))

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_similarity (out_ch.similarity)
);

`default_nettype wire

// ----- test/cosine_similarity_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_engine_tb
// Streams vector pairs through the engine with random gaps on both channels and
// compares every similarity word with a predictor built on real arithmetic,
// rounded to IEEE single after each step.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  bit   hold_req;
  bit   run_done;
  int   quiet_cycles;

  cse_in_if  in_ch ();
  cse_out_if out_ch ();

  cosine_similarity_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock: 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Widen an IEEE single pattern to a real
  function automatic real single_to_real(logic [31:0] x);
    real r;
    if (x[30:23] == 8'hFF) begin
      if (x[22:0] != 23'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({x[31], 11'h7FF, 52'd0});
    end
    if (x[30:23] == 8'd0) begin
      r = real'(x[22:0]) * (2.0 ** (-149));
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], {3'd0, x[30:23]} + 11'd896, x[22:0], 29'd0});
  endfunction

  // Round a real to IEEE single, nearest even
  function automatic logic [31:0] real_to_single(real v);
    logic [63:0] b;
    logic [63:0] sig, q, rest;
    int          e, sh;
    logic        rb, st;
    b = $realtobits(v);
    if (b[62:52] == 11'h7FF)
      return (b[51:0] != 52'd0) ? cse_pkg::CANON_NAN : {b[63], 8'hFF, 23'd0};
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    e   = int'(b[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, b[51:0]};
    sh  = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) sh = 60;
    q    = sig >> sh;
    rest = sig & ((64'd1 << sh) - 64'd1);
    rb   = rest[sh-1];
    st   = (rest & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    if (rb && (st || q[0])) q = q + 64'd1;
    if (e >= 1) begin
      if (q[24]) begin
        q = q >> 1;
        e = e + 1;
      end
      if (e >= 255) return {b[63], 8'hFF, 23'd0};
      return {b[63], 8'(e), q[22:0]};
    end
    return {b[63], q[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] x, logic [31:0] y);
    return real_to_single(single_to_real(x) * single_to_real(y));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] x, logic [31:0] y);
    return real_to_single(single_to_real(x) + single_to_real(y));
  endfunction

  // Tracks lane sums and holds the similarity words still to come
  class similarity_scoreboard;
    logic [31:0] dot_sum[cse_pkg::LANES];
    logic [31:0] sq_a_sum[cse_pkg::LANES];
    logic [31:0] sq_b_sum[cse_pkg::LANES];
    logic [31:0] similarity_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      for (int i = 0; i < cse_pkg::LANES; i++) begin
        dot_sum[i]  = 32'd0;
        sq_a_sum[i] = 32'd0;
        sq_b_sum[i] = 32'd0;
      end
    endfunction

    function logic [31:0] reduce(logic [31:0] v[cse_pkg::LANES]);
      logic [31:0] s;
      s = v[0];
      for (int i = 1; i < cse_pkg::LANES; i++) s = sp_add(s, v[i]);
      return s;
    endfunction

    // Fold one accepted item into the lane sums; finish the pair on last
    function void note_item(logic [cse_pkg::LANES-1:0][31:0] a,
                            logic [cse_pkg::LANES-1:0][31:0] b,
                            logic [cse_pkg::CNT_W-1:0] cnt, logic last);
      int          used;
      logic [31:0] dp, na, nb, den, r;
      used = (!last || cnt > cse_pkg::LANES) ? cse_pkg::LANES : int'(cnt);
      for (int i = 0; i < used; i++) begin
        dot_sum[i]  = sp_add(dot_sum[i], sp_mul(a[i], b[i]));
        sq_a_sum[i] = sp_add(sq_a_sum[i], sp_mul(a[i], a[i]));
        sq_b_sum[i] = sp_add(sq_b_sum[i], sp_mul(b[i], b[i]));
      end
      if (!last) return;
      dp  = reduce(dot_sum);
      na  = real_to_single($sqrt(single_to_real(reduce(sq_a_sum))));
      nb  = real_to_single($sqrt(single_to_real(reduce(sq_b_sum))));
      den = sp_mul(na, nb);
      r   = real_to_single(single_to_real(dp) / single_to_real(den));
      if (r[30:23] == 8'hFF && r[22:0] != 23'd0) r = cse_pkg::CANON_NAN;
      similarity_q.push_back(r);
      clear_sums();
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (similarity_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected similarity %h", got);
        return;
      end
      want = similarity_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("ERROR: similarity expected %h got %h", want, got);
      end
    endfunction
  endclass

  similarity_scoreboard board = new();

  // Observe transfers at the rising edge; watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_item(in_ch.a_lane, in_ch.b_lane, in_ch.valid_lanes, in_ch.last);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.similarity);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || run_done)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // Random element, biased toward moderate magnitudes
  function automatic logic [31:0] rand_elem();
    int k;
    k = $urandom_range(99);
    if (k < 70) return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    if (k < 78) return {1'($urandom), 31'd0};
    if (k < 84) return {1'($urandom), 8'd0, 23'($urandom)};
    if (k < 88) return {1'($urandom), 8'hFF, 23'd0};
    if (k < 91) return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
    if (k < 95) return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
    return $urandom;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(logic [cse_pkg::LANES-1:0][31:0] a,
                           logic [cse_pkg::LANES-1:0][31:0] b,
                           logic [cse_pkg::CNT_W-1:0] cnt, logic last);
    bit moved;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.a_lane      <= a;
    in_ch.b_lane      <= b;
    in_ch.valid_lanes <= cnt;
    in_ch.last        <= last;
    do begin
      @(posedge clk);
      moved = in_ch.valid && in_ch.ready;
    end while (!moved);
    @(negedge clk);
  endtask

  task automatic send_uniform(logic [31:0] av, logic [31:0] bv,
                              logic [cse_pkg::CNT_W-1:0] cnt);
    send_item({cse_pkg::LANES{av}}, {cse_pkg::LANES{bv}}, cnt, 1'b1);
  endtask

  // One vector pair with random content; last count mostly in range
  task automatic send_vector(int len);
    logic [cse_pkg::LANES-1:0][31:0] a, b;
    logic [cse_pkg::CNT_W-1:0]       cnt;
    for (int n = 0; n < len; n++) begin
      for (int i = 0; i < cse_pkg::LANES; i++) begin
        a[i] = rand_elem();
        b[i] = rand_elem();
      end
      cnt = ($urandom_range(9) == 0) ? cse_pkg::CNT_W'($urandom) :
                                       cse_pkg::CNT_W'($urandom_range(1, cse_pkg::LANES));
      send_item(a, b, cnt, n == len - 1);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.similarity_q.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(int s_idle, int r_idle, int items);
    int sent;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < items) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      send_vector(len);
      sent += len;
    end
  endtask

  initial begin
    logic [cse_pkg::LANES-1:0][31:0] a, b;
    in_ch.valid       = 1'b0;
    in_ch.a_lane      = '0;
    in_ch.b_lane      = '0;
    in_ch.valid_lanes = '0;
    in_ch.last        = 1'b0;
    send_idle         = 0;
    recv_idle         = 0;
    hold_req          = 1'b0;
    run_done          = 1'b0;
    quiet_cycles      = 0;
    rst_n             = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero vectors, unit vectors, extremes, specials, odd counts
    send_uniform(32'h0000_0000, 32'h0000_0000, 3'd4);
    send_uniform(32'h3F80_0000, 32'h3F80_0000, 3'd4);
    send_uniform(32'h3F80_0000, 32'hBF80_0000, 3'd4);
    send_uniform(32'h7F7F_FFFF, 32'h7F7F_FFFF, 3'd4);
    send_uniform(32'hFF7F_FFFF, 32'h7F7F_FFFF, 3'd2);
    send_uniform(32'h0000_0001, 32'h0000_0001, 3'd4);
    send_uniform(32'h007F_FFFF, 32'h8080_0000, 3'd3);
    send_uniform(32'h7F80_0000, 32'h3F80_0000, 3'd1);
    send_uniform(32'h7FC0_0001, 32'h3F80_0000, 3'd4);
    send_uniform(32'hFFFF_FFFF, 32'h7FFF_FFFF, 3'd4);
    send_uniform(32'h8000_0000, 32'h4000_0000, 3'd4);
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < cse_pkg::LANES; i++) begin
        a[i] = 32'h3F80_0000 + 32'(i) * 32'h0080_0000;
        b[i] = 32'h4000_0000 - 32'(c) * 32'h0010_0000;
      end
      send_item(a, b, 3'd4, 1'b0);
      send_item(b, a, cse_pkg::CNT_W'(c), 1'b1);
    end
    drain();

    // Random traffic in two idling mixes
    random_phase(28, 50, 150);
    drain();
    random_phase(50, 28, 150);

    // Long result hold-off while short vectors keep coming
    hold_req = 1'b1;
    random_phase(0, 0, 30);
    drain();
    random_phase(0, 0, 120);

    drain();
    repeat (200) @(negedge clk);
    run_done = 1'b1;
    if (board.errors == 0 && board.similarity_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
